// ===== hdl/regularized_ema_filter_core_macros.svh =====
// Assertion macros shared by the regularized EMA filter RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef REGULARIZED_EMA_FILTER_CORE_MACROS_SVH
`define REGULARIZED_EMA_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define REMA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define REMA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rema_pkg.sv =====
// Shared types, constants and the microcode table of the regularized EMA filter.
// Used by rema_seq, rema_div and regularized_ema_filter_core; depends on nothing.
`default_nettype none

package rema_pkg;

	localparam int unsigned PC_W       = 5;
	localparam int unsigned CNT_W      = 6;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;

	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd1;

	// Start-up phase codes.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_RUN    = 2'd2;

	localparam logic [15:0] PERIOD_RESET = 16'd10;
	localparam logic [23:0] LAMBDA_RESET = 24'd32768;
	localparam int unsigned ALPHA_NUM    = 131072;
	localparam logic [16:0] ALPHA_ONE    = 17'd65536;
	localparam logic [16:0] ALPHA_RESET  = 17'((ALPHA_NUM + 11 / 2) / 11);
	localparam logic [24:0] ONE_Q16      = 25'd65536;
	localparam logic [23:0] HALF_Q16     = 24'd32768;

	localparam int unsigned DIV_ALPHA_STEPS = 18;
	localparam int unsigned DIV_MAIN_STEPS  = 41;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_PH0,
		JC_PH1,
		JC_ALPHA_OK
	} jc_t;

	typedef enum logic [3:0] {
		ACC_NOP,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_ABS,
		ACC_HALF,
		ACC_SHQ,
		ACC_ADDY1,
		ACC_QUO,
		ACC_LDX
	} acc_op_t;

	typedef enum logic [1:0] {
		MUL_NOP,
		MUL_AD,
		MUL_Y1F,
		MUL_LY2
	} mul_op_t;

	typedef enum logic [1:0] {
		DV_NOP,
		DV_LD_ALPHA,
		DV_LD_MAIN,
		DV_STEP
	} div_op_t;

	typedef struct packed {
		logic    wait_in;
		logic    wait_out;
		logic    rep;
		jc_t     jc;
		pc_t     target;
		cnt_t    cnt;
		mul_op_t mul;
		acc_op_t acc;
		div_op_t dv;
		logic    diff_wr;
		logic    alpha_wr;
		logic    out_wr;
	} ucode_t;

	typedef struct packed {
		logic in_go;
		logic out_free;
		logic ph0;
		logic ph1;
		logic alpha_ok;
	} stat_t;

	// Program addresses that are jump targets.
	localparam pc_t PC_IDLE = 5'd0;
	localparam pc_t PC_DIFF = 5'd6;
	localparam pc_t PC_P1   = 5'd17;
	localparam pc_t PC_P0   = 5'd21;
	localparam pc_t PC_OUT  = 5'd22;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = '0;
		unique case (pc)
			PC_IDLE: w.wait_in = 1'b1;
			5'd1: begin
				w.jc     = JC_PH0;
				w.target = PC_P0;
			end
			5'd2: begin
				w.jc     = JC_ALPHA_OK;
				w.target = PC_DIFF;
			end
			5'd3: begin
				w.dv  = DV_LD_ALPHA;
				w.cnt = cnt_t'(DIV_ALPHA_STEPS - 1);
			end
			5'd4: begin
				w.dv  = DV_STEP;
				w.rep = 1'b1;
			end
			5'd5:    w.alpha_wr = 1'b1;
			PC_DIFF: w.diff_wr = 1'b1;
			5'd7:    w.mul = MUL_AD;
			5'd8: begin
				w.acc    = ACC_LOAD;
				w.jc     = JC_PH1;
				w.target = PC_P1;
			end
			5'd9: w.mul = MUL_Y1F;
			5'd10: begin
				w.acc = ACC_ADD;
				w.mul = MUL_LY2;
			end
			5'd11: w.acc = ACC_SUB;
			5'd12: w.acc = ACC_ABS;
			5'd13: w.acc = ACC_HALF;
			5'd14: begin
				w.dv  = DV_LD_MAIN;
				w.cnt = cnt_t'(DIV_MAIN_STEPS - 1);
			end
			5'd15: begin
				w.dv  = DV_STEP;
				w.rep = 1'b1;
			end
			5'd16: begin
				w.acc    = ACC_QUO;
				w.jc     = JC_ALWAYS;
				w.target = PC_OUT;
			end
			PC_P1: w.acc = ACC_ABS;
			5'd18: w.acc = ACC_HALF;
			5'd19: w.acc = ACC_SHQ;
			5'd20: begin
				w.acc    = ACC_ADDY1;
				w.jc     = JC_ALWAYS;
				w.target = PC_OUT;
			end
			PC_P0: w.acc = ACC_LDX;
			PC_OUT: begin
				w.wait_out = 1'b1;
				w.out_wr   = 1'b1;
				w.jc       = JC_ALWAYS;
				w.target   = PC_IDLE;
			end
			default: begin
				w.jc     = JC_ALWAYS;
				w.target = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/regularized_ema_filter_core.sv =====
// Regularized EMA filter: top level with the datapath, configuration and output register.
// Instantiates rema_seq and rema_div; depends on rema_pkg and the assertion macro header.
//
// Usage. Samples arrive on in_valid/in_stall/sample, one signed Q16.16 word each, and
// every sample gives one signed Q16.16 word on out_valid/out_stall/filtered, saturated.
// A word moves at a clock edge where valid is high and stall is low. The configuration
// channel (cfg_valid/cfg_ready/cfg_index/cfg_data) takes period at index 0 and the Q8.16
// lambda at index 1; cfg_ready is always high and other indexes are ignored. Write it
// only while no sample is in flight.
// Flow. One word is in work at a time. The first sample after reset is passed through to
// the output register, the second takes a path with no division, and every later one
// spends most of its work in the 41-step restoring division by one plus lambda. After a
// period write the next sample, unless it is the first after reset, first runs the
// 18-step division for alpha. The input is stalled from the cycle after acceptance until
// the result is loaded into the output register. A stalled output holds its word; the
// block keeps working on the next sample and waits at the output step until the register
// is free.
// Reset clears the phase, the stored outputs and the output valid, and restores period
// 10 and lambda 0.5.
`default_nettype none
`include "regularized_ema_filter_core_macros.svh"

module regularized_ema_filter_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [31:0]                  sample,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [31:0]                       filtered,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rema_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rema_pkg::CFG_DATA_W-1:0]     cfg_data
);

	rema_pkg::ucode_t uc;
	rema_pkg::stat_t  stat;

	logic [15:0]        period_q;
	logic [23:0]        lambda_q;
	logic [16:0]        alpha_q;
	logic               alpha_ok_q;
	logic [1:0]         phase_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y1_q;
	logic signed [31:0] y2_q;
	logic signed [32:0] diff_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [63:0] acc_d;
	logic               neg_q;
	logic signed [31:0] filtered_q;
	logic               out_valid_q;

	logic               in_go;
	logic               out_free;
	logic               out_go;
	logic               cfg_go;

	logic [15:0]        per_eff;
	logic [16:0]        per_div;
	logic [17:0]        alpha_num;
	logic [24:0]        lam_div;
	logic [23:0]        half;
	logic [25:0]        y1_gain;
	logic signed [32:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [59:0] mul_p;
	logic [24:0]        rem_init;
	logic [63:0]        sh_init;
	logic [24:0]        divisor;
	logic [63:0]        quo;
	logic signed [63:0] q_mag;
	logic signed [31:0] sat_y;

	assign cfg_ready = 1'b1;
	assign cfg_go    = cfg_valid && cfg_ready;
	assign in_stall  = !uc.wait_in;
	assign in_go     = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_go    = uc.out_wr && out_free;
	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;

	always_comb begin
		stat.in_go    = in_go;
		stat.out_free = out_free;
		stat.ph0      = phase_q == rema_pkg::PH_FIRST;
		stat.ph1      = phase_q == rema_pkg::PH_SECOND;
		stat.alpha_ok = alpha_ok_q;
	end

	rema_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uc     (uc)
	);

	// Divider operands: alpha is round(2^17 / (period + 1)), the output divides by 1 + lambda.
	always_comb begin
		per_eff   = (period_q == '0) ? 16'd1 : period_q;
		per_div   = {1'b0, per_eff} + 17'd1;
		alpha_num = 18'(rema_pkg::ALPHA_NUM) + {2'b00, per_div[16:1]};
		lam_div   = {1'b0, lambda_q} + rema_pkg::ONE_Q16;
		half      = (phase_q == rema_pkg::PH_SECOND) ? rema_pkg::HALF_Q16 : lam_div[24:1];
		y1_gain   = {1'b0, rema_pkg::ONE_Q16} + {1'b0, lambda_q, 1'b0};
		if (uc.dv == rema_pkg::DV_LD_ALPHA) begin
			rem_init = '0;
			sh_init  = {alpha_num, 46'd0};
			divisor  = {8'd0, per_div};
		end else begin
			// The rounded numerator stays below 2^57, so its top 16 bits are below the divisor.
			rem_init = {9'd0, acc_q[56:41]};
			sh_init  = {acc_q[40:0], 23'd0};
			divisor  = lam_div;
		end
	end

	rema_div u_div (
		.clk      (clk),
		.op       (uc.dv),
		.rem_init (rem_init),
		.sh_init  (sh_init),
		.divisor  (divisor),
		.quo      (quo)
	);

	always_comb begin
		unique case (uc.mul)
			rema_pkg::MUL_Y1F: begin
				mul_a = {y1_q[31], y1_q};
				mul_b = {1'b0, y1_gain};
			end
			rema_pkg::MUL_LY2: begin
				mul_a = {y2_q[31], y2_q};
				mul_b = {3'b000, lambda_q};
			end
			default: begin
				mul_a = diff_q;
				mul_b = {10'd0, alpha_q};
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		q_mag = '0;
		unique case (uc.acc)
			rema_pkg::ACC_LOAD:  acc_d = prod_q;
			rema_pkg::ACC_ADD:   acc_d = acc_q + prod_q;
			rema_pkg::ACC_SUB:   acc_d = acc_q - prod_q;
			rema_pkg::ACC_ABS:   acc_d = acc_q[63] ? -acc_q : acc_q;
			rema_pkg::ACC_HALF:  acc_d = acc_q + $signed({40'd0, half});
			rema_pkg::ACC_SHQ: begin
				q_mag = $signed({16'd0, acc_q[63:16]});
				acc_d = neg_q ? -q_mag : q_mag;
			end
			rema_pkg::ACC_ADDY1: acc_d = acc_q + 64'(y1_q);
			rema_pkg::ACC_QUO: begin
				q_mag = $signed({23'd0, quo[40:0]});
				acc_d = neg_q ? -q_mag : q_mag;
			end
			rema_pkg::ACC_LDX:   acc_d = 64'(x_q);
			default:             acc_d = acc_q;
		endcase
		if ((&acc_q[63:31]) || !(|acc_q[63:31])) begin
			sat_y = acc_q[31:0];
		end else begin
			sat_y = acc_q[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
	end

	// Datapath payload registers.
	always_ff @(posedge clk) begin
		if (in_go) begin
			x_q <= sample;
		end
		if (uc.diff_wr) begin
			diff_q <= {x_q[31], x_q} - {y1_q[31], y1_q};
		end
		if (uc.mul != rema_pkg::MUL_NOP) begin
			prod_q <= 64'(mul_p);
		end
		acc_q <= acc_d;
		if (uc.acc == rema_pkg::ACC_ABS) begin
			neg_q <= acc_q[63];
		end
	end

	// Control state, configuration and filter history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= rema_pkg::PERIOD_RESET;
			lambda_q    <= rema_pkg::LAMBDA_RESET;
			alpha_q     <= rema_pkg::ALPHA_RESET;
			alpha_ok_q  <= 1'b1;
			phase_q     <= rema_pkg::PH_FIRST;
			y1_q        <= '0;
			y2_q        <= '0;
			filtered_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (uc.alpha_wr) begin
				alpha_q    <= quo[16:0];
				alpha_ok_q <= 1'b1;
			end
			if (cfg_go) begin
				if (cfg_index == rema_pkg::REG_PERIOD) begin
					period_q   <= cfg_data[15:0];
					alpha_ok_q <= 1'b0;
				end else if (cfg_index == rema_pkg::REG_LAMBDA) begin
					lambda_q <= cfg_data[23:0];
				end
			end
			if (out_go) begin
				filtered_q  <= sat_y;
				out_valid_q <= 1'b1;
				y1_q        <= sat_y;
				if (phase_q != rema_pkg::PH_FIRST) begin
					y2_q <= y1_q;
				end
				phase_q <= (phase_q == rema_pkg::PH_FIRST) ? rema_pkg::PH_SECOND
					: rema_pkg::PH_RUN;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`REMA_ASSERT_NEXT(a_out_leaves_first, out_go, phase_q != rema_pkg::PH_FIRST, "phase did not advance")
	`REMA_ASSERT_NEXT(a_out_returns_idle, out_go, !in_stall, "sequencer not idle after output")
	`REMA_ASSERT_NEXT(a_accept_busy, in_go, in_stall, "input not stalled after accept")
	`REMA_ASSERT_NOW(a_alpha_range, alpha_ok_q, (alpha_q != '0) && (alpha_q <= rema_pkg::ALPHA_ONE), "alpha out of range")

endmodule

`default_nettype wire

// ===== hdl/rema_seq.sv =====
// Microcode sequencer: step counter, repeat counter and conditional jumps.
// Reads its program from rema_pkg::ucode_rom; depends on rema_pkg.
`default_nettype none

module rema_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rema_pkg::stat_t stat,
	output rema_pkg::ucode_t     uc
);

	rema_pkg::pc_t  pc_q;
	rema_pkg::cnt_t cnt_q;
	logic           hold;
	logic           take;

	assign uc = rema_pkg::ucode_rom(pc_q);

	always_comb begin
		hold = (uc.wait_in && !stat.in_go) || (uc.wait_out && !stat.out_free)
			|| (uc.rep && (cnt_q != '0));
		unique case (uc.jc)
			rema_pkg::JC_NEVER:    take = 1'b0;
			rema_pkg::JC_ALWAYS:   take = 1'b1;
			rema_pkg::JC_PH0:      take = stat.ph0;
			rema_pkg::JC_PH1:      take = stat.ph1;
			rema_pkg::JC_ALPHA_OK: take = stat.alpha_ok;
			default:               take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= rema_pkg::PC_IDLE;
			cnt_q <= '0;
		end else begin
			if (!hold) begin
				pc_q <= take ? uc.target : pc_q + rema_pkg::pc_t'(1);
			end
			// A repeat step counts down what the step before it loaded.
			if (uc.rep) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - rema_pkg::cnt_t'(1);
				end
			end else begin
				cnt_q <= uc.cnt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rema_div.sv =====
// Restoring divider, one quotient bit per step, shared by the alpha and output divisions.
// The caller preloads the partial remainder and the dividend bits; depends on rema_pkg.
`default_nettype none

module rema_div (
	input  wire logic              clk,
	input  wire rema_pkg::div_op_t op,
	input  wire logic [24:0]       rem_init,
	input  wire logic [63:0]       sh_init,
	input  wire logic [24:0]       divisor,
	output logic      [63:0]       quo
);

	logic [24:0] rem_q;
	logic [24:0] div_q;
	logic [63:0] sh_q;
	logic [25:0] trial;
	logic [25:0] diff;
	logic        fits;

	always_comb begin
		trial = {rem_q, sh_q[63]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		unique case (op)
			rema_pkg::DV_LD_ALPHA, rema_pkg::DV_LD_MAIN: begin
				rem_q <= rem_init;
				sh_q  <= sh_init;
				div_q <= divisor;
			end
			rema_pkg::DV_STEP: begin
				// Quotient bits enter at the bottom as dividend bits leave the top.
				rem_q <= fits ? diff[24:0] : trial[24:0];
				sh_q  <= {sh_q[62:0], fits};
			end
			default: begin
			end
		endcase
	end

	assign quo = sh_q;

endmodule

`default_nettype wire
